// ----- hw/rtl/fbpm_pkg.sv -----
`timescale 1ns / 1ps

package fbpm_pkg;

  // Default pool size
  localparam int unsigned NUM_BUFFERS_DEF = 8;

  // Fixed field widths
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned BUFNUM_W = 8;
  localparam int unsigned CHOSEN_W = 3;
  localparam int unsigned SEQ_W    = 32;
  localparam int unsigned TOTAL_W  = 4;

  // Buffer flag encodings: bit0 queued, bit1 done
  localparam logic [1:0] FLAG_IDLE   = 2'b00;
  localparam logic [1:0] FLAG_QUEUED = 2'b01;
  localparam logic [1:0] FLAG_DONE   = 2'b10;

  typedef enum logic [CMD_W-1:0] {
    CMD_QUEUE       = 3'd0,
    CMD_MARK_DONE   = 3'd1,
    CMD_TAKE_OLDEST = 3'd2,
    CMD_TAKE_NEXT   = 3'd3,
    CMD_WRITE       = 3'd4,
    CMD_READ        = 3'd5,
    CMD_QUERY       = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_NONE      = 2'd2,
    ST_DROPPED   = 2'd3
  } status_e;

  // Control for the shared compare unit
  typedef struct packed {
    logic clear;   // start a new search
    logic step;    // evaluate one candidate
    logic oldest;  // 1: lowest sequence wins, 0: first hit wins
  } cmp_ctrl_t;

  // Write control for the buffer store
  typedef struct packed {
    logic       flag_we;
    logic       seq_we;
    logic [1:0] flags;
  } st_wr_t;

endpackage

// ----- hw/rtl/fbpm_cmp_unit.sv -----
`timescale 1ns / 1ps

// Shared search unit: one candidate per cycle, keeps the best so far.
module fbpm_cmp_unit #(
  parameter int unsigned IDX_W = 3
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  fbpm_pkg::cmp_ctrl_t     ctrl_i,
  input  logic [IDX_W-1:0]        cand_idx_i,
  input  logic                    cand_hit_i,
  input  logic [fbpm_pkg::SEQ_W-1:0] cand_seq_i,
  output logic                    found_o,
  output logic [IDX_W-1:0]        best_idx_o
);
  import fbpm_pkg::*;

  logic             found_q, found_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  logic [SEQ_W-1:0] best_seq_q, best_seq_d;
  logic             take;

  // single 32-bit compare shared by both search kinds
  assign take = cand_hit_i && (!found_q || (ctrl_i.oldest && (cand_seq_i < best_seq_q)));

  always_comb begin
    found_d    = found_q;
    best_idx_d = best_idx_q;
    best_seq_d = best_seq_q;
    if (ctrl_i.clear) begin
      found_d = 1'b0;
    end else if (ctrl_i.step && take) begin
      found_d    = 1'b1;
      best_idx_d = cand_idx_i;
      best_seq_d = cand_seq_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q <= best_idx_d;
    best_seq_q <= best_seq_d;
  end

  assign found_o    = found_q;
  assign best_idx_o = best_idx_q;

endmodule

// ----- hw/rtl/fbpm_buf_store.sv -----
`timescale 1ns / 1ps

// Per-buffer flags and sequence numbers, plus running queued/done counts.
module fbpm_buf_store #(
  parameter int unsigned NUM_BUFFERS = 8,
  parameter int unsigned IDX_W       = 3,
  parameter int unsigned CNT_W       = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fbpm_pkg::st_wr_t           wr_i,
  input  logic [IDX_W-1:0]           wr_idx_i,
  input  logic [fbpm_pkg::SEQ_W-1:0] wr_seq_i,
  input  logic [IDX_W-1:0]           rd_idx_i,
  output logic [1:0]                 rd_flags_o,
  output logic [fbpm_pkg::SEQ_W-1:0] rd_seq_o,
  output logic [CNT_W-1:0]           queued_cnt_o,
  output logic [CNT_W-1:0]           done_cnt_o
);
  import fbpm_pkg::*;

  logic [1:0]       flags_q [NUM_BUFFERS];
  logic [SEQ_W-1:0] seq_q   [NUM_BUFFERS];
  logic [CNT_W-1:0] queued_cnt_q, queued_cnt_d;
  logic [CNT_W-1:0] done_cnt_q, done_cnt_d;
  logic [1:0]       old_flags;

  assign old_flags = flags_q[wr_idx_i];

  always_comb begin
    queued_cnt_d = queued_cnt_q;
    done_cnt_d   = done_cnt_q;
    if (wr_i.flag_we) begin
      queued_cnt_d = queued_cnt_q - CNT_W'(old_flags[0]) + CNT_W'(wr_i.flags[0]);
      done_cnt_d   = done_cnt_q - CNT_W'(old_flags[1]) + CNT_W'(wr_i.flags[1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        flags_q[i] <= FLAG_IDLE;
        seq_q[i]   <= '0;
      end
      queued_cnt_q <= '0;
      done_cnt_q   <= '0;
    end else begin
      if (wr_i.flag_we) begin
        flags_q[wr_idx_i] <= wr_i.flags;
      end
      if (wr_i.seq_we) begin
        seq_q[wr_idx_i] <= wr_seq_i;
      end
      queued_cnt_q <= queued_cnt_d;
      done_cnt_q   <= done_cnt_d;
    end
  end

  assign rd_flags_o   = flags_q[rd_idx_i];
  assign rd_seq_o     = seq_q[rd_idx_i];
  assign queued_cnt_o = queued_cnt_q;
  assign done_cnt_o   = done_cnt_q;

`ifndef NO_ASSERTIONS
  logic [NUM_BUFFERS-1:0] q_vec, d_vec;
  always_comb begin
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      q_vec[i] = flags_q[i][0];
      d_vec[i] = flags_q[i][1];
    end
  end

  a_queued_cnt_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(q_vec) == 32'(queued_cnt_q))
    else $error("queued count out of step with flags");

  a_done_cnt_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(d_vec) == 32'(done_cnt_q))
    else $error("done count out of step with flags");

  a_no_dual_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_vec & d_vec) == '0)
    else $error("buffer both queued and done");
`endif

endmodule

// ----- hw/rtl/frame_buffer_pool_manager_core.sv -----
`timescale 1ns / 1ps

// Frame buffer pool manager. Tracks NUM_BUFFERS buffers, each idle, queued
// (free for the producer) or done (filled, waiting for the consumer), and
// answers every command beat with exactly one result beat carrying status,
// buffer index, stored sequence, flags and the queued/done totals.
// Commands: queue, mark done, take oldest done (lowest sequence, ties to the
// lowest index), take next queued (round robin), write (take next queued,
// stamp the frame counter, mark done), read (oldest done back to queued) and
// query. Queue, mark done and query with a good index pass through the
// update and response states; an unused command code and any rejected
// command go straight to the response state; take-oldest, take-next, write
// and read first run a search, which walks the buffer table one entry per
// cycle through a single shared 32-bit compare unit, followed by the pick,
// update and response states (a search with no hit skips the update).
// One command is in flight at a time; in_ready_o is high only while the
// sequencer is idle, and a finished result sits in the output register so
// the next command beat can be taken before that result is drained.
module frame_buffer_pool_manager_core #(
  parameter int unsigned NUM_BUFFERS = fbpm_pkg::NUM_BUFFERS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [fbpm_pkg::CMD_W-1:0]    cmd_i,
  input  logic [fbpm_pkg::BUFNUM_W-1:0] buffer_number_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [fbpm_pkg::CHOSEN_W-1:0] chosen_buffer_o,
  output logic [fbpm_pkg::SEQ_W-1:0]    frame_sequence_o,
  output logic                          is_queued_o,
  output logic                          is_done_o,
  output logic [fbpm_pkg::TOTAL_W-1:0]  queued_total_o,
  output logic [fbpm_pkg::TOTAL_W-1:0]  done_total_o
);
  import fbpm_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_BUFFERS);
  localparam int unsigned CNT_W = $clog2(NUM_BUFFERS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUFFERS - 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,  // one table entry per cycle into the compare unit
    S_PICK   = 5'b00100,  // take the search winner
    S_UPDATE = 5'b01000,  // write flags / sequence, adjust counts
    S_RESP   = 5'b10000   // load the output register
  } state_e;

  state_e           state_q, state_d;
  cmd_e             cmd_q, cmd_d;
  status_e          status_q, status_d;
  logic             has_buf_q, has_buf_d;   // result names a buffer
  logic [IDX_W-1:0] buf_q, buf_d;           // buffer acted on
  logic [IDX_W-1:0] ptr_q, ptr_d;           // scan address
  logic [IDX_W-1:0] step_q, step_d;         // entries scanned so far
  logic [IDX_W-1:0] write_start_q, write_start_d;
  logic [IDX_W-1:0] take_start_q, take_start_d;
  logic [SEQ_W-1:0] frame_cnt_q, frame_cnt_d;

  // output register
  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic [CHOSEN_W-1:0] out_buf_q, out_buf_d;
  logic [SEQ_W-1:0]    out_seq_q, out_seq_d;
  logic                out_queued_q, out_queued_d;
  logic                out_done_q, out_done_d;
  logic [TOTAL_W-1:0]  out_qtot_q, out_qtot_d;
  logic [TOTAL_W-1:0]  out_dtot_q, out_dtot_d;

  // store and compare unit hookup
  st_wr_t           st_wr;
  logic [IDX_W-1:0] rd_idx;
  logic [1:0]       rd_flags;
  logic [SEQ_W-1:0] rd_seq;
  logic [CNT_W-1:0] queued_cnt, done_cnt;
  cmp_ctrl_t        cmp_ctrl;
  logic             cmp_found;
  logic [IDX_W-1:0] cmp_best;
  logic             cand_hit;

  logic             in_beat, out_free, bad_idx;
  logic [IDX_W+CHOSEN_W-1:0] buf_ext;
  logic [CNT_W+TOTAL_W-1:0]  qcnt_ext, dcnt_ext;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign bad_idx    = buffer_number_i >= BUFNUM_W'(NUM_BUFFERS);

  // Read port follows the scan pointer while searching, else the chosen buffer
  assign rd_idx   = (state_q == S_SCAN) ? ptr_q : buf_q;
  assign cand_hit = cmp_ctrl.oldest ? rd_flags[1] : rd_flags[0];

  // width adaptation of internal index/counts to the fixed result fields
  assign buf_ext  = {{CHOSEN_W{1'b0}}, buf_q};
  assign qcnt_ext = {{TOTAL_W{1'b0}}, queued_cnt};
  assign dcnt_ext = {{TOTAL_W{1'b0}}, done_cnt};

  fbpm_buf_store #(
    .NUM_BUFFERS (NUM_BUFFERS),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (st_wr),
    .wr_idx_i     (buf_q),
    .wr_seq_i     (frame_cnt_q),
    .rd_idx_i     (rd_idx),
    .rd_flags_o   (rd_flags),
    .rd_seq_o     (rd_seq),
    .queued_cnt_o (queued_cnt),
    .done_cnt_o   (done_cnt)
  );

  fbpm_cmp_unit #(
    .IDX_W (IDX_W)
  ) u_cmp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (cmp_ctrl),
    .cand_idx_i (ptr_q),
    .cand_hit_i (cand_hit),
    .cand_seq_i (rd_seq),
    .found_o    (cmp_found),
    .best_idx_o (cmp_best)
  );

  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    status_d      = status_q;
    has_buf_d     = has_buf_q;
    buf_d         = buf_q;
    ptr_d         = ptr_q;
    step_d        = step_q;
    write_start_d = write_start_q;
    take_start_d  = take_start_q;
    frame_cnt_d   = frame_cnt_q;

    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_buf_d    = out_buf_q;
    out_seq_d    = out_seq_q;
    out_queued_d = out_queued_q;
    out_done_d   = out_done_q;
    out_qtot_d   = out_qtot_q;
    out_dtot_d   = out_dtot_q;

    st_wr           = '0;
    cmp_ctrl        = '0;
    // oldest-done searches for take-oldest and read, first-queued otherwise
    cmp_ctrl.oldest = (cmd_q == CMD_TAKE_OLDEST) || (cmd_q == CMD_READ);

    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          cmd_d          = cmd_e'(cmd_i);
          buf_d          = buffer_number_i[IDX_W-1:0];
          step_d         = '0;
          has_buf_d      = 1'b0;
          status_d       = ST_OK;
          cmp_ctrl.clear = 1'b1;
          state_d        = S_RESP;
          case (cmd_e'(cmd_i))
            CMD_QUEUE, CMD_MARK_DONE, CMD_QUERY: begin
              if (bad_idx) begin
                status_d = ST_BAD_INDEX;
              end else begin
                has_buf_d = 1'b1;
                state_d   = S_UPDATE;
              end
            end
            CMD_TAKE_OLDEST, CMD_READ: begin
              if (done_cnt == '0) begin
                status_d = ST_NONE;
              end else begin
                ptr_d   = '0;
                state_d = S_SCAN;
              end
            end
            CMD_TAKE_NEXT: begin
              if (queued_cnt == '0) begin
                status_d = ST_NONE;
              end else begin
                ptr_d   = take_start_q;
                state_d = S_SCAN;
              end
            end
            CMD_WRITE: begin
              if (queued_cnt == '0) begin
                status_d = ST_DROPPED;
              end else begin
                ptr_d   = write_start_q;
                state_d = S_SCAN;
              end
            end
            default: begin
              // unused code: no change, plain ok
            end
          endcase
        end
      end

      S_SCAN: begin
        cmp_ctrl.step = 1'b1;
        ptr_d  = (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == LAST_IDX) begin
          state_d = S_PICK;
        end
      end

      S_PICK: begin
        if (cmp_found) begin
          buf_d     = cmp_best;
          has_buf_d = 1'b1;
          state_d   = S_UPDATE;
        end else begin
          status_d = (cmd_q == CMD_WRITE) ? ST_DROPPED : ST_NONE;
          state_d  = S_RESP;
        end
      end

      S_UPDATE: begin
        state_d = S_RESP;
        case (cmd_q)
          CMD_QUEUE, CMD_READ: begin
            st_wr.flag_we = 1'b1;
            st_wr.flags   = FLAG_QUEUED;
          end
          CMD_MARK_DONE: begin
            st_wr.flag_we = 1'b1;
            st_wr.flags   = FLAG_DONE;
          end
          CMD_TAKE_OLDEST: begin
            st_wr.flag_we = 1'b1;
            st_wr.flags   = FLAG_IDLE;
          end
          CMD_TAKE_NEXT: begin
            st_wr.flag_we = 1'b1;
            st_wr.flags   = FLAG_IDLE;
            take_start_d  = buf_q;
          end
          CMD_WRITE: begin
            st_wr.flag_we = 1'b1;
            st_wr.seq_we  = 1'b1;
            st_wr.flags   = FLAG_DONE;
            frame_cnt_d   = frame_cnt_q + 1'b1;
            write_start_d = buf_q;
          end
          default: begin
            // query: read only
          end
        endcase
      end

      S_RESP: begin
        // store already reflects the update; wait for a free output slot
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_qtot_d   = qcnt_ext[TOTAL_W-1:0];
          out_dtot_d   = dcnt_ext[TOTAL_W-1:0];
          if (has_buf_q) begin
            out_buf_d    = buf_ext[CHOSEN_W-1:0];
            out_seq_d    = rd_seq;
            out_queued_d = rd_flags[0];
            out_done_d   = rd_flags[1];
          end else begin
            out_buf_d    = '0;
            out_seq_d    = '0;
            out_queued_d = 1'b0;
            out_done_d   = 1'b0;
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      write_start_q <= '0;
      take_start_q  <= '0;
      frame_cnt_q   <= '0;
      out_valid_q   <= 1'b0;
      has_buf_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      write_start_q <= write_start_d;
      take_start_q  <= take_start_d;
      frame_cnt_q   <= frame_cnt_d;
      out_valid_q   <= out_valid_d;
      has_buf_q     <= has_buf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    status_q     <= status_d;
    buf_q        <= buf_d;
    ptr_q        <= ptr_d;
    step_q       <= step_d;
    out_status_q <= out_status_d;
    out_buf_q    <= out_buf_d;
    out_seq_q    <= out_seq_d;
    out_queued_q <= out_queued_d;
    out_done_q   <= out_done_d;
    out_qtot_q   <= out_qtot_d;
    out_dtot_q   <= out_dtot_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign chosen_buffer_o  = out_buf_q;
  assign frame_sequence_o = out_seq_q;
  assign is_queued_o      = out_queued_q;
  assign is_done_o        = out_done_q;
  assign queued_total_o   = out_qtot_q;
  assign done_total_o     = out_dtot_q;

`ifndef NO_ASSERTIONS
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !in_ready_o)
    else $error("command beat taken while a command is in flight");

  a_frame_cnt_only_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_cnt_q != $past(frame_cnt_q)) |->
      ($past(state_q) == S_UPDATE && $past(cmd_q) == CMD_WRITE))
    else $error("frame counter moved outside a write update");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(status_o) && $stable(chosen_buffer_o) &&
       $stable(frame_sequence_o) && $stable(queued_total_o) && $stable(done_total_o)))
    else $error("result beat changed while waiting for ready");
`endif

endmodule
